>>> design/usts_pkg.sv
// Package for the unordered set table unit: operation and status codes,
// default sizes and the control record that travels down the cell row.
// Used by usts_cell and unordered_set_table_unit; depends on nothing.
package usts_pkg;

   localparam int DEPTH_DEFAULT       = 128;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_MAX    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL_EMPTY = 2'd1,
      STATUS_MISS       = 2'd2
   } status_type;

   // Control part of the probe that walks the row, one cell per cycle.
   typedef struct packed {
      logic     active;
      func_type func;
      logic     found;
      logic     have_max;
   } probe_ctrl_type;

endpackage

>>> design/usts_cell.sv
// One cell of the table row: holds one entry and processes the probe as it
// passes, then hands the probe on to the next cell.
// Depends on usts_pkg.
module usts_cell #(
   parameter int DEPTH       = usts_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = usts_pkg::VALUE_WIDTH_DEFAULT,
   parameter int INDEX       = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(DEPTH+1)-1:0]     count,
   input  usts_pkg::probe_ctrl_type       ctrl_in,
   input  logic [VALUE_WIDTH-1:0]         value_in,
   input  logic [$clog2(DEPTH)-1:0]       pos_in,
   input  logic [VALUE_WIDTH-1:0]         maxv_in,
   input  logic [VALUE_WIDTH-1:0]         next_entry,
   output logic [VALUE_WIDTH-1:0]         entry_out,
   output usts_pkg::probe_ctrl_type       ctrl_out,
   output logic [VALUE_WIDTH-1:0]         value_out,
   output logic [$clog2(DEPTH)-1:0]       pos_out,
   output logic [VALUE_WIDTH-1:0]         maxv_out
);
   import usts_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] MY_POS = PW'(INDEX);
   localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

   logic [VALUE_WIDTH-1:0] entry_ff, entry_in;
   probe_ctrl_type         ctrl_ff, ctrl_nxt_in;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [PW-1:0]          pos_ff, pos_nxt_in;
   logic [VALUE_WIDTH-1:0] maxv_ff, maxv_nxt_in;
   logic                   occupied;
   logic                   match;

   always_comb begin
      occupied    = MY_CNT < count;
      match       = ctrl_in.active && occupied && (entry_ff == value_in);
      ctrl_nxt_in = ctrl_in;
      pos_nxt_in  = pos_in;
      maxv_nxt_in = maxv_in;
      entry_in    = entry_ff;

      ctrl_nxt_in.found = ctrl_in.found | match;
      if (!ctrl_in.found && match) begin
         pos_nxt_in = MY_POS;
      end

      if (ctrl_in.active && occupied &&
          (!ctrl_in.have_max || ($signed(entry_ff) > $signed(maxv_in)))) begin
         maxv_nxt_in          = entry_ff;
         ctrl_nxt_in.have_max = 1'b1;
      end

      if (ctrl_in.active) begin
         // A delete pulls every entry from the first match onward down by one.
         if (ctrl_in.func == FUNC_DELETE && (ctrl_in.found || match)) begin
            entry_in = next_entry;
         end
         // An insert lands in the first free cell when no copy was seen.
         if (ctrl_in.func == FUNC_INSERT && !ctrl_in.found && MY_CNT == count) begin
            entry_in = value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_nxt_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      value_ff <= value_in;
      pos_ff   <= pos_nxt_in;
      maxv_ff  <= maxv_nxt_in;
   end

   assign entry_out = entry_ff;
   assign ctrl_out  = ctrl_ff;
   assign value_out = value_ff;
   assign pos_out   = pos_ff;
   assign maxv_out  = maxv_ff;

endmodule

>>> design/unordered_set_table_unit.sv
// Top level of the unordered set table unit: request intake, the row of
// table cells, result forming and the two-deep result buffer.
// Depends on usts_pkg and usts_cell.
//
//   Channel  | Signals                                   | Direction
//   ---------+-------------------------------------------+----------
//   request  | req_valid, req_ready, req_func, req_value | in
//   response | rsp_valid, rsp_ready, rsp_status,         | out
//            | rsp_position, rsp_max_value, rsp_count    |
//
// A transaction registers the request, then the probe walks the row of
// DEPTH cells, registered in each cell in turn, and the result is registered
// as the probe leaves the last cell. One transaction is in the row at a time.
// Reset is synchronous and active high and empties the table (count zero).
// A result that is not taken waits in the output register; a second result
// can wait behind it, and a new request is refused only while that second
// slot is full or the row is busy.
module unordered_set_table_unit #(
   parameter int DEPTH       = usts_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = usts_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_func,
   input  logic [VALUE_WIDTH-1:0]       req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [$clog2(DEPTH)-1:0]     rsp_position,
   output logic [VALUE_WIDTH-1:0]       rsp_max_value,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_count
);
   import usts_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // Table occupancy and the busy flag of the row.
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;

   // Registered request, which feeds the first cell.
   probe_ctrl_type         issue_ctrl_ff, issue_ctrl_in;
   logic [VALUE_WIDTH-1:0] issue_value_ff;

   // Probe links between cells; link 0 is the registered request.
   probe_ctrl_type         ctrl_chain  [0:DEPTH];
   logic [VALUE_WIDTH-1:0] value_chain [0:DEPTH];
   logic [PW-1:0]          pos_chain   [0:DEPTH];
   logic [VALUE_WIDTH-1:0] maxv_chain  [0:DEPTH];
   logic [VALUE_WIDTH-1:0] entry_row   [0:DEPTH-1];

   // Result of the probe leaving the last cell.
   logic                   done;
   status_type             res_status;
   logic [PW-1:0]          res_pos;
   logic [VALUE_WIDTH-1:0] res_max;
   logic [CW-1:0]          res_count;

   // Output register and the slot behind it.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   pend_valid_ff, pend_valid_in;
   status_type             rsp_status_ff, rsp_status_in, pend_status_ff, pend_status_in;
   logic [PW-1:0]          rsp_pos_ff, rsp_pos_in, pend_pos_ff, pend_pos_in;
   logic [VALUE_WIDTH-1:0] rsp_max_ff, rsp_max_in, pend_max_ff, pend_max_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in, pend_count_ff, pend_count_in;

   logic accept;
   logic rsp_free;

   assign req_ready = !busy_ff && !pend_valid_ff;
   assign accept    = req_valid && req_ready;

   // Request intake.
   always_comb begin
      issue_ctrl_in          = '0;
      issue_ctrl_in.active   = accept;
      issue_ctrl_in.func     = func_type'(req_func);
      issue_ctrl_in.found    = 1'b0;
      issue_ctrl_in.have_max = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ctrl_ff <= '0;
      end else begin
         issue_ctrl_ff <= issue_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         issue_value_ff <= req_value;
      end
   end

   assign ctrl_chain[0]  = issue_ctrl_ff;
   assign value_chain[0] = issue_value_ff;
   assign pos_chain[0]   = '0;
   assign maxv_chain[0]  = '0;

   // The row of cells. Each cell but the last sees its upper neighbor's entry
   // (the last sees its own) so that a delete can close the gap as the probe passes.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] next_entry;

      if (i == DEPTH - 1) begin : g_last
         assign next_entry = entry_row[i];
      end else begin : g_inner
         assign next_entry = entry_row[i + 1];
      end

      usts_cell #(
         .DEPTH       (DEPTH),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count      (count_ff),
         .ctrl_in    (ctrl_chain[i]),
         .value_in   (value_chain[i]),
         .pos_in     (pos_chain[i]),
         .maxv_in    (maxv_chain[i]),
         .next_entry (next_entry),
         .entry_out  (entry_row[i]),
         .ctrl_out   (ctrl_chain[i + 1]),
         .value_out  (value_chain[i + 1]),
         .pos_out    (pos_chain[i + 1]),
         .maxv_out   (maxv_chain[i + 1])
      );
   end

   // Turn the probe leaving the row into a transaction result. The count
   // stays fixed while the probe walks, so it is settled only here.
   always_comb begin
      done       = ctrl_chain[DEPTH].active;
      res_status = STATUS_OK;
      res_pos    = '0;
      res_max    = '0;
      res_count  = count_ff;

      unique case (ctrl_chain[DEPTH].func)
         FUNC_INSERT: begin
            if (count_ff >= FULL_COUNT) begin
               res_status = STATUS_FULL_EMPTY;
            end else if (ctrl_chain[DEPTH].found) begin
               res_status = STATUS_MISS;
            end else begin
               res_count = count_ff + CW'(1);
            end
         end
         FUNC_DELETE: begin
            if (count_ff == '0) begin
               res_status = STATUS_FULL_EMPTY;
            end else if (!ctrl_chain[DEPTH].found) begin
               res_status = STATUS_MISS;
            end else begin
               res_pos   = pos_chain[DEPTH];
               res_count = count_ff - CW'(1);
            end
         end
         FUNC_SEARCH: begin
            if (!ctrl_chain[DEPTH].found) begin
               res_status = STATUS_MISS;
            end else begin
               res_pos = pos_chain[DEPTH];
            end
         end
         FUNC_MAX: begin
            if (count_ff == '0) begin
               res_status = STATUS_FULL_EMPTY;
            end else begin
               res_max = maxv_chain[DEPTH];
            end
         end
         default: begin
            res_status = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (done) begin
         busy_in  = 1'b0;
         count_in = res_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // Result buffering. The second slot is only ever filled while the output
   // register is stalled, and drains into it as soon as that is taken.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      pend_valid_in  = pend_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_max_in     = rsp_max_ff;
      rsp_count_in   = rsp_count_ff;
      pend_status_in = pend_status_ff;
      pend_pos_in    = pend_pos_ff;
      pend_max_in    = pend_max_ff;
      pend_count_in  = pend_count_ff;

      if (done) begin
         if (rsp_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status;
            rsp_pos_in    = res_pos;
            rsp_max_in    = res_max;
            rsp_count_in  = res_count;
         end else begin
            pend_valid_in  = 1'b1;
            pend_status_in = res_status;
            pend_pos_in    = res_pos;
            pend_max_in    = res_max;
            pend_count_in  = res_count;
         end
      end else if (pend_valid_ff && rsp_free) begin
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
         rsp_status_in = pend_status_ff;
         rsp_pos_in    = pend_pos_ff;
         rsp_max_in    = pend_max_ff;
         rsp_count_in  = pend_count_ff;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_max_ff     <= rsp_max_in;
      rsp_count_ff   <= rsp_count_in;
      pend_status_ff <= pend_status_in;
      pend_pos_ff    <= pend_pos_in;
      pend_max_ff    <= pend_max_in;
      pend_count_ff  <= pend_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_count     = rsp_count_ff;

endmodule
